FILE: hdl/thruster_allocation_mixer_core_macros.svh
// Assertion macros shared by the thruster mixer RTL.
`ifndef THRUSTER_ALLOCATION_MIXER_CORE_MACROS_SVH
`define THRUSTER_ALLOCATION_MIXER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TAM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tam_pkg.sv
// Shared types and constants for the thruster allocation mixer.
package tam_pkg;

    localparam int DEFAULT_THRUSTER_COUNT = 8;
    localparam int AXES       = 6;
    localparam int Q_W        = 16;
    localparam int SEL_W      = 3;
    localparam int ID_W       = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int FRAC_SHIFT = 14;
    localparam int PROD_W     = 2 * Q_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 3;
    localparam int SH_W       = SUM_W - FRAC_SHIFT;

    localparam logic signed [Q_W-1:0] LO_LIMIT_RESET = 16'sh8000;
    localparam logic signed [Q_W-1:0] HI_LIMIT_RESET = 16'sh7FFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LO_LIMIT = 1'b0,
        CFG_HI_LIMIT = 1'b1
    } cfg_reg_t;

    // Input item kinds.
    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_MIX  = 1'b1
    } item_kind_t;

    // One 16-bit word per axis.
    typedef logic [AXES-1:0][Q_W-1:0] axis_vec_t;

    // Control tag that travels with each thruster row through the pipeline.
    typedef struct packed {
        logic            vld;
        logic [ID_W-1:0] id;
        logic            last;
    } pipe_tag_t;

endpackage

FILE: hdl/tam_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface tam_item_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic        [tam_pkg::SEL_W-1:0]  thruster_sel;
    logic        [tam_pkg::SEL_W-1:0]  axis_sel;
    logic signed [tam_pkg::Q_W-1:0]    coefficient;
    logic signed [tam_pkg::Q_W-1:0]    surge_cmd;
    logic signed [tam_pkg::Q_W-1:0]    sway_cmd;
    logic signed [tam_pkg::Q_W-1:0]    heave_cmd;
    logic signed [tam_pkg::Q_W-1:0]    yaw_cmd;
    logic signed [tam_pkg::Q_W-1:0]    pitch_cmd;
    logic signed [tam_pkg::Q_W-1:0]    roll_cmd;

    modport source (
        output valid, kind, thruster_sel, axis_sel, coefficient,
               surge_cmd, sway_cmd, heave_cmd, yaw_cmd, pitch_cmd, roll_cmd,
        input  ready
    );
    modport sink (
        input  valid, kind, thruster_sel, axis_sel, coefficient,
               surge_cmd, sway_cmd, heave_cmd, yaw_cmd, pitch_cmd, roll_cmd,
        output ready
    );
endinterface

interface tam_result_if;
    logic                            valid;
    logic                            ready;
    logic        [tam_pkg::ID_W-1:0] thruster_id;
    logic signed [tam_pkg::Q_W-1:0]  thrust_out;
    logic                            last;

    modport source (output valid, thruster_id, thrust_out, last, input ready);
    modport sink   (input valid, thruster_id, thrust_out, last, output ready);
endinterface

interface tam_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic        [tam_pkg::CFG_IDX_W-1:0] index;
    logic signed [tam_pkg::Q_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/thruster_allocation_mixer_core.sv
// Top level of the thruster allocation mixer: table, sequencer and pipeline.
//
//  channel  | role   | transaction
//  ---------+--------+-----------------------------------------------------
//  item     | sink   | load one coefficient, or mix six axis commands
//  result   | source | one clamped drive value per thruster, last flagged
//  cfg      | sink   | write the lower clamp (index 0) or upper clamp (index 1)
//
// A mix issues one thruster row per cycle from the coefficient table while
// the result channel is not stalled; the next item is taken in the cycle of
// the last row's issue. Each row passes the stage 1 register and the
// product, pair-sum, shift and clamp registers before its result appears.
// Reset clears one valid bit per table entry; an unwritten entry reads zero.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
`include "thruster_allocation_mixer_core_macros.svh"

module thruster_allocation_mixer_core #(
    parameter int THRUSTER_COUNT = tam_pkg::DEFAULT_THRUSTER_COUNT
) (
    input  logic          clk,
    input  logic          rst_n,
    tam_item_if.sink      item,
    tam_result_if.source  result,
    tam_cfg_if.sink       cfg
);

    localparam int IDX_W = (THRUSTER_COUNT > 1) ? $clog2(THRUSTER_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(THRUSTER_COUNT - 1);
    localparam logic [tam_pkg::ID_W-1:0] LAST_ID = tam_pkg::ID_W'(THRUSTER_COUNT - 1);

    logic                           busy_reg, busy_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    tam_pkg::axis_vec_t             cmd_reg;
    logic signed [tam_pkg::Q_W-1:0] min_reg, max_reg;
    logic [THRUSTER_COUNT-1:0][tam_pkg::AXES-1:0] tbl_vld_reg;

    tam_pkg::pipe_tag_t             s1_tag_reg;
    logic [tam_pkg::AXES-1:0]       s1_mask_reg;
    tam_pkg::axis_vec_t             s1_cmd_reg;
    tam_pkg::axis_vec_t             coef_rd;
    tam_pkg::pipe_tag_t             out_tag;
    logic signed [tam_pkg::Q_W-1:0] thrust;

    logic                           advance;
    logic                           issue_last;
    logic                           accept;
    logic                           mix_acc;
    logic                           load_acc;
    logic                           row_ok;
    logic                           col_ok;
    logic [IDX_W-1:0]               wr_row;

    // Handshake and pipeline control.
    assign advance    = !out_tag.vld || result.ready;
    assign issue_last = busy_reg && (idx_reg == LAST_IDX);
    assign item.ready = !busy_reg || (advance && issue_last);
    assign accept     = item.valid && item.ready;
    assign mix_acc    = accept && (item.kind == tam_pkg::KIND_MIX);
    assign load_acc   = accept && (item.kind == tam_pkg::KIND_LOAD);

    // Range check on the coefficient address of a load.
    assign row_ok = {1'b0, item.thruster_sel} < (tam_pkg::SEL_W + 1)'(THRUSTER_COUNT);
    assign col_ok = item.axis_sel < tam_pkg::SEL_W'(tam_pkg::AXES);
    assign wr_row = item.thruster_sel[IDX_W-1:0];

    // Row sequencer for mix transactions.
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (mix_acc)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (advance && busy_reg)
        begin
            if (issue_last)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Axis commands are held for the whole mix.
    always_ff @(posedge clk)
    begin
        if (mix_acc)
        begin
            cmd_reg <= {item.roll_cmd, item.pitch_cmd, item.yaw_cmd,
                        item.heave_cmd, item.sway_cmd, item.surge_cmd};
        end
    end

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= tam_pkg::LO_LIMIT_RESET;
            max_reg <= tam_pkg::HI_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                tam_pkg::CFG_LO_LIMIT: min_reg <= cfg.data;
                tam_pkg::CFG_HI_LIMIT: max_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Valid bit per table entry, cleared by reset, set by a load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_vld_reg <= '0;
        end
        else if (load_acc && row_ok && col_ok)
        begin
            tbl_vld_reg[wr_row][item.axis_sel] <= 1'b1;
        end
    end

    // One coefficient memory per axis column, addressed by thruster row.
    for (genvar c = 0; c < tam_pkg::AXES; c++)
    begin : g_col
        tam_ram #(
            .WIDTH (tam_pkg::Q_W),
            .DEPTH (THRUSTER_COUNT)
        ) u_col_ram (
            .clk   (clk),
            .we    (load_acc && row_ok && (item.axis_sel == tam_pkg::SEL_W'(c))),
            .waddr (wr_row),
            .wdata (item.coefficient),
            .re    (advance),
            .raddr (idx_reg),
            .rdata (coef_rd[c])
        );
    end

    // Stage 1: row read, issued alongside the memory read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
        end
        else if (advance)
        begin
            s1_tag_reg.vld  <= busy_reg;
            s1_tag_reg.id   <= tam_pkg::ID_W'(idx_reg);
            s1_tag_reg.last <= issue_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_mask_reg <= tbl_vld_reg[idx_reg];
            s1_cmd_reg  <= cmd_reg;
        end
    end

    // Stages 2 to 5.
    tam_mix_pipe u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_tag   (s1_tag_reg),
        .coef_vec (coef_rd),
        .coef_mask(s1_mask_reg),
        .cmd_vec  (s1_cmd_reg),
        .lo_limit (min_reg),
        .hi_limit (max_reg),
        .out_tag  (out_tag),
        .thrust   (thrust)
    );

    // Result channel driven straight from the last pipeline register.
    assign result.valid       = out_tag.vld;
    assign result.thruster_id = out_tag.id;
    assign result.last        = out_tag.last;
    assign result.thrust_out  = thrust;

    // A mix transaction starts issuing at row zero.
    `TAM_ASSERT_NEXT(a_mix_start, clk, rst_n, mix_acc, busy_reg && idx_reg == '0, "bad mix start")
    // The sequencer only goes idle after issuing the final row.
    `TAM_ASSERT_NOW(a_busy_end, clk, rst_n, $fell(busy_reg), $past(idx_reg) == LAST_IDX, "early idle")
    // The last flag belongs to the highest thruster index.
    `TAM_ASSERT_NOW(a_last_id, clk, rst_n, out_tag.last, out_tag.id == LAST_ID, "stray last flag")

endmodule

FILE: hdl/tam_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read in the same cycle as a
    // write to the same address returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/tam_mix_pipe.sv
// Multiply, reduce, shift and clamp pipeline for one thruster row per cycle while advance is high.
module tam_mix_pipe (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  tam_pkg::pipe_tag_t             in_tag,
    input  tam_pkg::axis_vec_t             coef_vec,
    input  logic [tam_pkg::AXES-1:0]       coef_mask,
    input  tam_pkg::axis_vec_t             cmd_vec,
    input  logic signed [tam_pkg::Q_W-1:0] lo_limit,
    input  logic signed [tam_pkg::Q_W-1:0] hi_limit,
    output tam_pkg::pipe_tag_t             out_tag,
    output logic signed [tam_pkg::Q_W-1:0] thrust
);

    localparam int NPAIR = tam_pkg::AXES / 2;

    tam_pkg::pipe_tag_t t2_reg, t3_reg, t4_reg, t5_reg;

    logic signed [tam_pkg::PROD_W-1:0] prod_next [tam_pkg::AXES];
    logic signed [tam_pkg::PROD_W-1:0] prod_reg  [tam_pkg::AXES];
    logic signed [tam_pkg::PAIR_W-1:0] pair_next [NPAIR];
    logic signed [tam_pkg::PAIR_W-1:0] pair_reg  [NPAIR];
    logic signed [tam_pkg::SUM_W-1:0]  sum_full;
    logic signed [tam_pkg::SH_W-1:0]   sh_next, sh_reg;
    logic signed [tam_pkg::SH_W-1:0]   max_ext, min_ext;
    logic signed [tam_pkg::Q_W-1:0]    thrust_next, thrust_reg;

    // Stage 2: six products, a coefficient never written reads as zero.
    always_comb
    begin
        logic signed [tam_pkg::Q_W-1:0] ce;
        logic signed [tam_pkg::Q_W-1:0] cm;
        for (int a = 0; a < tam_pkg::AXES; a++)
        begin
            ce = coef_mask[a] ? $signed(coef_vec[a]) : '0;
            cm = $signed(cmd_vec[a]);
            prod_next[a] = ce * cm;
        end
    end

    // Stage 3: pairwise sums of the products.
    always_comb
    begin
        for (int p = 0; p < NPAIR; p++)
        begin
            pair_next[p] = tam_pkg::PAIR_W'(prod_reg[2*p])
                         + tam_pkg::PAIR_W'(prod_reg[2*p+1]);
        end
    end

    // Stage 4: full sum, then the arithmetic shift is a plain part-select.
    always_comb
    begin
        sum_full = tam_pkg::SUM_W'(pair_reg[0])
                 + tam_pkg::SUM_W'(pair_reg[1])
                 + tam_pkg::SUM_W'(pair_reg[2]);
        sh_next  = sum_full[tam_pkg::SUM_W-1:tam_pkg::FRAC_SHIFT];
    end

    // Stage 5: clamp, the upper bound is tested first.
    always_comb
    begin
        max_ext = tam_pkg::SH_W'(hi_limit);
        min_ext = tam_pkg::SH_W'(lo_limit);
        if (sh_reg > max_ext)
        begin
            thrust_next = hi_limit;
        end
        else if (sh_reg < min_ext)
        begin
            thrust_next = lo_limit;
        end
        else
        begin
            thrust_next = sh_reg[tam_pkg::Q_W-1:0];
        end
    end

    // Control tags move with the data and freeze on a stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
            t5_reg <= '0;
        end
        else if (advance)
        begin
            t2_reg <= in_tag;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
            t5_reg <= t4_reg;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg   <= prod_next;
            pair_reg   <= pair_next;
            sh_reg     <= sh_next;
            thrust_reg <= thrust_next;
        end
    end

    assign out_tag = t5_reg;
    assign thrust  = thrust_reg;

endmodule
